@@ hw/rtl/bphd_pkg.sv @@
// ----------------------------------------------------------------------------
// Bar meter package
// Widths, constants and the per-bar state type of the peak-hold bar meter.
// ----------------------------------------------------------------------------
package bphd_pkg;

    localparam int BARS       = 128;
    localparam int HEIGHT     = 32;

    localparam int IDX_W      = $clog2(BARS);
    localparam int HGT_W      = $clog2(HEIGHT);
    localparam int PEAK_W     = HGT_W + 1;
    localparam int MAG_W      = 16;
    localparam int GAIN_W     = 10;
    localparam int PROD_W     = MAG_W + GAIN_W;
    localparam int SCALE_W    = PROD_W - MAG_W;
    localparam int CNT_W      = 2;

    localparam logic [GAIN_W-1:0]  GAIN_RESET = GAIN_W'(256);
    localparam logic [SCALE_W-1:0] SCALE_MAX  = SCALE_W'(HEIGHT - 1);
    localparam logic [HGT_W-1:0]   HGT_MAX    = HGT_W'(HEIGHT - 1);
    localparam logic [HGT_W-1:0]   FALL_STEP  = HGT_W'(2);
    localparam logic [PEAK_W-1:0]  PEAK_STEP  = PEAK_W'(1);
    localparam logic [PEAK_W-1:0]  PEAK_FLOOR = PEAK_W'(1);
    localparam logic [PEAK_W-1:0]  PEAK_TOP   = PEAK_W'(HEIGHT);
    localparam logic [CNT_W-1:0]   CNT_STEP   = CNT_W'(1);
    localparam logic [CNT_W-1:0]   CNT_LAST   = CNT_W'(2);

    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [PEAK_W-1:0] peak;
        logic [HGT_W-1:0]  shown;
    } t_bar_state;

    localparam t_bar_state STATE_RESET = '{cnt: '0, peak: PEAK_TOP, shown: '0};

endpackage

@@ hw/rtl/bphd_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Bar meter configuration channel
// Carries one gain word per write with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bphd_cfg_if;

    logic                        valid;
    logic                        ready;
    logic [bphd_pkg::GAIN_W-1:0] gain;

    modport source (output valid, output gain, input ready);
    modport sink (input valid, input gain, output ready);

endinterface

@@ hw/rtl/bphd_in_if.sv @@
// ----------------------------------------------------------------------------
// Bar meter input channel
// Carries one bar index and its level per word.
// ----------------------------------------------------------------------------
interface bphd_in_if;

    logic                       valid;
    logic                       ready;
    logic [bphd_pkg::IDX_W-1:0] bar_index;
    logic [bphd_pkg::MAG_W-1:0] magnitude;

    modport source (output valid, output bar_index, output magnitude, input ready);
    modport sink (input valid, input bar_index, input magnitude, output ready);

endinterface

@@ hw/rtl/bphd_out_if.sv @@
// ----------------------------------------------------------------------------
// Bar meter output channel
// Carries the bar index, the shown height and the peak row per word.
// ----------------------------------------------------------------------------
interface bphd_out_if;

    logic                        valid;
    logic                        ready;
    logic [bphd_pkg::IDX_W-1:0]  bar_out_index;
    logic [bphd_pkg::HGT_W-1:0]  bar_height;
    logic [bphd_pkg::PEAK_W-1:0] peak_height;

    modport source (output valid, output bar_out_index, output bar_height,
                    output peak_height, input ready);
    modport sink (input valid, input bar_out_index, input bar_height,
                  input peak_height, output ready);

endinterface

@@ hw/rtl/bar_peak_hold_decay_top.sv @@
// ----------------------------------------------------------------------------
// Peak-hold bar meter
// Scales each bar level by the gain, raises or lets the bar fall, and moves
// its peak marker; the per-bar state sits in an internal memory.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one word per bar update: the bar index and the
// level as an unsigned fraction of full scale. The output channel returns one
// word for each input word, in order: the index, the new bar height and the
// peak row. The configuration channel writes the gain and is always ready;
// write it only while no words are in flight.
// The pipeline has three register stages: the multiplier with the state
// memory read, the clamp with state forwarding, and the update into the
// output register. An accepted word moves from the first stage through the
// second into the output register, and one word per cycle is sustained
// while the receiver is ready. The single write port of the state memory
// sets that rate; a repeated bar index is served by forwarding from the two
// stages ahead, so back-to-back updates of the same bar need no stall.
// Reset clears all bars at once (height 0, peak above the visible area) and
// sets the gain to 256. When the receiver stalls, the stages fill up behind
// the output register and input ready falls only once all of them are full.
// ----------------------------------------------------------------------------
module bar_peak_hold_decay_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bphd_cfg_if.sink    i_cfg_ch,
    bphd_in_if.sink     i_in_ch,
    bphd_out_if.source  o_out_ch
);

    logic [bphd_pkg::GAIN_W-1:0] r_gain;

    logic                         s1_en;
    logic                         s2_en;
    logic                         out_en;
    logic                         wr_en;

    logic                         r_s1_valid;
    logic [bphd_pkg::IDX_W-1:0]   r_s1_idx;
    logic [bphd_pkg::PROD_W-1:0]  r_s1_prod;
    bphd_pkg::t_bar_state         r_s1_rd;
    logic                         r_s1_rd_vld;

    logic [bphd_pkg::SCALE_W-1:0] s1_scaled;
    logic [bphd_pkg::HGT_W-1:0]   s1_target;
    bphd_pkg::t_bar_state         s1_state;

    logic                         r_s2_valid;
    logic [bphd_pkg::IDX_W-1:0]   r_s2_idx;
    logic [bphd_pkg::HGT_W-1:0]   r_s2_target;
    bphd_pkg::t_bar_state         r_s2_state;
    bphd_pkg::t_bar_state         n_s2_state;

    logic                         r_out_valid;
    logic [bphd_pkg::IDX_W-1:0]   r_out_idx;
    bphd_pkg::t_bar_state         r_out_state;
    logic                         r_fwd_valid;

    bphd_pkg::t_bar_state         r_state_mem [bphd_pkg::BARS];
    logic [bphd_pkg::BARS-1:0]    r_bar_vld;

    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= bphd_pkg::GAIN_RESET;
        end else if (i_cfg_ch.valid) begin
            r_gain <= i_cfg_ch.gain;
        end
    end

    assign out_en         = !r_out_valid || o_out_ch.ready;
    assign s2_en          = !r_s2_valid || out_en;
    assign s1_en          = !r_s1_valid || s2_en;
    assign wr_en          = r_s2_valid && out_en;
    assign i_in_ch.ready  = s1_en;

    // Stage 1: scale the level and read the bar state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_en) begin
            r_s1_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_s1_idx    <= i_in_ch.bar_index;
            r_s1_prod   <= bphd_pkg::PROD_W'(i_in_ch.magnitude)
                         * bphd_pkg::PROD_W'(r_gain);
            r_s1_rd     <= r_state_mem[i_in_ch.bar_index];
            r_s1_rd_vld <= r_bar_vld[i_in_ch.bar_index];
        end
    end

    // Stage 2: clamp the target and pick up the newest state of the bar.
    assign s1_scaled = r_s1_prod[bphd_pkg::PROD_W-1:bphd_pkg::MAG_W];
    assign s1_target = (s1_scaled > bphd_pkg::SCALE_MAX) ? bphd_pkg::HGT_MAX
                                                         : s1_scaled[bphd_pkg::HGT_W-1:0];

    always_comb begin
        priority if (r_s2_valid && (r_s2_idx == r_s1_idx)) begin
            s1_state = n_s2_state;
        end else if (r_fwd_valid && (r_out_idx == r_s1_idx)) begin
            s1_state = r_out_state;
        end else if (r_s1_rd_vld) begin
            s1_state = r_s1_rd;
        end else begin
            s1_state = bphd_pkg::STATE_RESET;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_en) begin
            r_s2_idx    <= r_s1_idx;
            r_s2_target <= s1_target;
            r_s2_state  <= s1_state;
        end
    end

    // Stage 3: rise or fall, then write back and present the result.
    always_comb begin
        n_s2_state = r_s2_state;
        if (r_s2_target > r_s2_state.shown) begin
            n_s2_state.shown = r_s2_target;
            if (bphd_pkg::PEAK_W'(r_s2_target) >= r_s2_state.peak) begin
                n_s2_state.peak = bphd_pkg::PEAK_W'(r_s2_target);
            end
        end else begin
            n_s2_state.shown = (r_s2_state.shown >= bphd_pkg::FALL_STEP)
                             ? r_s2_state.shown - bphd_pkg::FALL_STEP : '0;
            if (r_s2_state.cnt >= bphd_pkg::CNT_LAST) begin
                n_s2_state.cnt  = '0;
                n_s2_state.peak = (r_s2_state.peak > bphd_pkg::PEAK_FLOOR)
                                ? r_s2_state.peak - bphd_pkg::PEAK_STEP
                                : bphd_pkg::PEAK_FLOOR;
            end else begin
                n_s2_state.cnt = r_s2_state.cnt + bphd_pkg::CNT_STEP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_bar_vld   <= '0;
        end else begin
            if (out_en) begin
                r_out_valid <= r_s2_valid;
            end
            if (wr_en) begin
                r_fwd_valid         <= 1'b1;
                r_bar_vld[r_s2_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_out_idx             <= r_s2_idx;
            r_out_state           <= n_s2_state;
            r_state_mem[r_s2_idx] <= n_s2_state;
        end
    end

    assign o_out_ch.valid         = r_out_valid;
    assign o_out_ch.bar_out_index = r_out_idx;
    assign o_out_ch.bar_height    = r_out_state.shown;
    assign o_out_ch.peak_height   = r_out_state.peak;

    a_write_marks_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_bar_vld[$past(r_s2_idx)])
        else $error("State write did not mark the bar as written.");

    a_out_from_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s2_valid))
        else $error("Output word appeared without a word in stage 2.");

    a_s2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !out_en) |=> (r_s2_valid && $stable(r_s2_idx)))
        else $error("Stage 2 word changed while the output was stalled.");

    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_state.peak >= bphd_pkg::PEAK_FLOOR)
                         && (r_out_state.peak <= bphd_pkg::PEAK_TOP)
                         && (r_out_state.cnt <= bphd_pkg::CNT_LAST)))
        else $error("Bar state left its legal range.");

endmodule
